// ===== hdl/sogs_pkg.sv =====
`default_nettype none
package sogs_pkg;

	localparam int MAX_SIDE      = 1024;
	localparam int SIDE_BITS     = 10;
	localparam int GROUP_SIZE    = 4;
	localparam int MAX_RESTARTS  = 64;
	localparam int OUT_SLOTS     = 4;

	localparam int WIDTH_BITS    = 11;
	localparam int COUNT_BITS    = 21;
	localparam int DIST_BITS     = 11;
	localparam int SEED_BITS     = 64;
	localparam int DSQ_BITS      = 2 * DIST_BITS;

	localparam int CFG_IDX_BITS  = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_WIDTH = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_COUNT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_DISTANCE = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SEED         = 2'd3;

	localparam logic [WIDTH_BITS-1:0] RST_ORIGIN_WIDTH = 11'd1024;
	localparam logic [COUNT_BITS-1:0] RST_ORIGIN_COUNT = 21'd1048576;

	localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
	localparam int SHIFT_A = 30;
	localparam int SHIFT_B = 27;
	localparam int SHIFT_C = 31;

	typedef logic [SIDE_BITS-1:0] coord_t;

	typedef struct packed {
		logic start;
		logic new_attempt;
		logic scan_init;
		logic scan_step;
		logic pick;
		logic lim_start;
		logic lim_store;
		logic gen_start;
		logic rank_start;
		logic rank_store;
		logic next_slot;
		logic set_ok;
		logic emit;
	} sogs_cmd_t;

	typedef struct packed {
		logic scan_end;
		logic hit;
		logic n_zero;
		logic att_last;
		logic slot_last;
		logic gen_done;
		logic mod_done;
		logic below_limit;
	} sogs_sts_t;

	typedef struct packed {
		coord_t first_x;
		coord_t first_y;
		coord_t second_x;
		coord_t second_y;
		coord_t third_x;
		coord_t third_y;
		coord_t fourth_x;
		coord_t fourth_y;
		logic   ok;
	} sogs_res_t;

endpackage
`default_nettype wire

// ===== hdl/sogs_if.sv =====
`default_nettype none
interface sogs_req_if;
	logic valid;
	logic ready;
	logic request;
	modport source (output valid, output request, input ready);
	modport sink (input valid, input request, output ready);
endinterface

interface sogs_res_if;
	logic       valid;
	logic       ready;
	logic [9:0] first_x;
	logic [9:0] first_y;
	logic [9:0] second_x;
	logic [9:0] second_y;
	logic [9:0] third_x;
	logic [9:0] third_y;
	logic [9:0] fourth_x;
	logic [9:0] fourth_y;
	logic       ok;
	modport source (output valid, output first_x, output first_y, output second_x,
		output second_y, output third_x, output third_y, output fourth_x,
		output fourth_y, output ok, input ready);
	modport sink (input valid, input first_x, input first_y, input second_x,
		input second_y, input third_x, input third_y, input fourth_x,
		input fourth_y, input ok, output ready);
endinterface
`default_nettype wire

// ===== hdl/sogs_mix.sv =====
`default_nettype none
module sogs_mix (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire logic [63:0] load_val,
	input  wire logic        start,
	output logic             done,
	output logic [63:0]      word
);
	import sogs_pkg::*;

	logic [63:0] st_q, z_q, acc_q, prod_q;
	logic [2:0]  ph_q;
	logic        second_q, done_q;
	logic [63:0] c, s, sum;
	logic [31:0] ma, mb;

	assign c   = second_q ? MIX_C2 : MIX_C1;
	assign ma  = (ph_q == 3'd3) ? z_q[63:32] : z_q[31:0];
	assign mb  = (ph_q == 3'd2) ? c[63:32] : c[31:0];
	assign s   = st_q + GOLDEN;
	assign sum = acc_q + {prod_q[31:0], 32'b0};

	// The 64-bit products keep only their low half, built from three 32x32 parts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '0;
			ph_q     <= '0;
			second_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				st_q <= load_val;
			end
			unique case (ph_q)
				3'd0: begin
					if (start) begin
						st_q     <= s;
						z_q      <= s ^ (s >> SHIFT_A);
						second_q <= 1'b0;
						ph_q     <= 3'd1;
					end
				end
				3'd1: begin
					prod_q <= ma * mb;
					ph_q   <= 3'd2;
				end
				3'd2: begin
					acc_q  <= prod_q;
					prod_q <= ma * mb;
					ph_q   <= 3'd3;
				end
				3'd3: begin
					acc_q  <= sum;
					prod_q <= ma * mb;
					ph_q   <= 3'd4;
				end
				3'd4: begin
					if (second_q) begin
						z_q    <= sum ^ (sum >> SHIFT_C);
						ph_q   <= 3'd0;
						done_q <= 1'b1;
					end else begin
						z_q      <= sum ^ (sum >> SHIFT_B);
						second_q <= 1'b1;
						ph_q     <= 3'd1;
					end
				end
				default: ph_q <= 3'd0;
			endcase
		end
	end

	assign done = done_q;
	assign word = z_q;
endmodule
`default_nettype wire

// ===== hdl/sogs_mod.sv =====
`default_nettype none
module sogs_mod (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [63:0]                     dividend,
	input  wire logic [sogs_pkg::COUNT_BITS-1:0] divisor,
	output logic                                 done,
	output logic [sogs_pkg::COUNT_BITS-1:0]      rem
);
	import sogs_pkg::*;

	logic [63:0]           a_q;
	logic [COUNT_BITS-1:0] b_q, rem_q;
	logic [6:0]            cnt_q;
	logic                  done_q;
	logic [COUNT_BITS:0]   t;

	// Restoring remainder, one dividend bit per cycle.
	assign t = {rem_q, a_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q   <= dividend;
				b_q   <= divisor;
				rem_q <= '0;
				cnt_q <= 7'd64;
			end else if (cnt_q != 7'd0) begin
				if (t >= {1'b0, b_q}) begin
					rem_q <= COUNT_BITS'(t - {1'b0, b_q});
				end else begin
					rem_q <= COUNT_BITS'(t);
				end
				a_q   <= a_q << 1;
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

// ===== hdl/sogs_ctrl.sv =====
`default_nettype none
module sogs_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_fire,
	input  wire logic                request,
	input  wire logic                out_free,
	input  wire sogs_pkg::sogs_sts_t sts,
	output logic                     in_ready,
	output sogs_pkg::sogs_cmd_t      cmd
);
	import sogs_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_START = 4'd1;
	localparam logic [3:0] S_ATT   = 4'd2;
	localparam logic [3:0] S_CINIT = 4'd3;
	localparam logic [3:0] S_COUNT = 4'd4;
	localparam logic [3:0] S_LIMIT = 4'd5;
	localparam logic [3:0] S_GEN   = 4'd6;
	localparam logic [3:0] S_RANK  = 4'd7;
	localparam logic [3:0] S_PINIT = 4'd8;
	localparam logic [3:0] S_PICK  = 4'd9;
	localparam logic [3:0] S_NEXT  = 4'd10;
	localparam logic [3:0] S_EMIT  = 4'd11;

	logic [3:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (req_fire && request) begin
					state_d = S_START;
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				state_d   = S_ATT;
			end
			S_ATT: begin
				cmd.new_attempt = 1'b1;
				state_d         = S_CINIT;
			end
			S_CINIT: begin
				cmd.scan_init = 1'b1;
				state_d       = S_COUNT;
			end
			S_COUNT: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_end) begin
					if (!sts.n_zero) begin
						cmd.lim_start = 1'b1;
						state_d       = S_LIMIT;
					end else if (sts.att_last) begin
						state_d = S_EMIT;
					end else begin
						state_d = S_ATT;
					end
				end
			end
			S_LIMIT: begin
				if (sts.mod_done) begin
					cmd.lim_store = 1'b1;
					cmd.gen_start = 1'b1;
					state_d       = S_GEN;
				end
			end
			S_GEN: begin
				// Words below the limit are drawn again so the rank stays unbiased.
				if (sts.gen_done) begin
					if (sts.below_limit) begin
						cmd.gen_start = 1'b1;
					end else begin
						cmd.rank_start = 1'b1;
						state_d        = S_RANK;
					end
				end
			end
			S_RANK: begin
				if (sts.mod_done) begin
					cmd.rank_store = 1'b1;
					state_d        = S_PINIT;
				end
			end
			S_PINIT: begin
				cmd.scan_init = 1'b1;
				state_d       = S_PICK;
			end
			S_PICK: begin
				cmd.scan_step = 1'b1;
				cmd.pick      = 1'b1;
				if (sts.hit) begin
					state_d = S_NEXT;
				end
			end
			S_NEXT: begin
				cmd.next_slot = 1'b1;
				if (sts.slot_last) begin
					cmd.set_ok = 1'b1;
					state_d    = S_EMIT;
				end else begin
					state_d = S_CINIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/sogs_dp.sv =====
`default_nettype none
module sogs_dp #(
	parameter int GROUP_SIZE   = sogs_pkg::GROUP_SIZE,
	parameter int MAX_RESTARTS = sogs_pkg::MAX_RESTARTS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sogs_pkg::sogs_cmd_t               cmd,
	input  wire logic [sogs_pkg::WIDTH_BITS-1:0]   origin_width,
	input  wire logic [sogs_pkg::COUNT_BITS-1:0]   origin_count,
	input  wire logic [sogs_pkg::DIST_BITS-1:0]    min_distance,
	input  wire logic                              seed_load,
	input  wire logic [sogs_pkg::SEED_BITS-1:0]    seed,
	output sogs_pkg::sogs_sts_t                    sts,
	output sogs_pkg::sogs_res_t                    res
);
	import sogs_pkg::*;

	localparam int KW = $clog2(GROUP_SIZE);
	localparam int AW = $clog2(MAX_RESTARTS + 1);

	logic [WIDTH_BITS-1:0] eff_w_q;
	logic [COUNT_BITS-1:0] eff_cnt_q, idx_q, n_q, rank_q, limit_q;
	logic [DSQ_BITS-1:0]   dsq_q;
	coord_t                x_q, y_q;
	logic [KW-1:0]         k_q, slot_q;
	logic [AW-1:0]         att_q;
	logic                  ok_q;
	coord_t                cx_q [GROUP_SIZE];
	coord_t                cy_q [GROUP_SIZE];

	logic [WIDTH_BITS-1:0] w_clamp;
	logic [COUNT_BITS-1:0] cnt_lim;
	coord_t                px, py, dx, dy;
	logic [2*SIDE_BITS:0]  dsum;
	logic                  sep, all_checked, take, scan_end;
	logic                  gen_done, mod_done;
	logic [63:0]           word, dividend;
	logic [COUNT_BITS-1:0] rem;

	always_comb begin
		if (origin_width == '0) begin
			w_clamp = WIDTH_BITS'(1);
		end else if (origin_width > WIDTH_BITS'(MAX_SIDE)) begin
			w_clamp = WIDTH_BITS'(MAX_SIDE);
		end else begin
			w_clamp = origin_width;
		end
		cnt_lim = COUNT_BITS'(w_clamp) << SIDE_BITS;
	end

	// One already chosen slot is checked against the candidate per cycle.
	assign px          = cx_q[k_q];
	assign py          = cy_q[k_q];
	assign dx          = (x_q > px) ? x_q - px : px - x_q;
	assign dy          = (y_q > py) ? y_q - py : py - y_q;
	assign dsum        = (2*SIDE_BITS+1)'(dx * dx) + (2*SIDE_BITS+1)'(dy * dy);
	assign sep         = !(x_q == px && y_q == py) && ({1'b0, dsum} >= dsq_q);
	assign all_checked = (k_q == slot_q);
	assign scan_end    = (idx_q == eff_cnt_q);
	assign take        = cmd.scan_step && !scan_end && all_checked && cmd.pick
		&& (n_q == rank_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q  <= '0;
			ok_q   <= 1'b0;
			slot_q <= '0;
			k_q    <= '0;
		end else begin
			if (cmd.start) begin
				eff_w_q   <= w_clamp;
				eff_cnt_q <= (origin_count > cnt_lim) ? cnt_lim : origin_count;
				dsq_q     <= min_distance * min_distance;
				att_q     <= '0;
				ok_q      <= 1'b0;
			end
			if (cmd.new_attempt) begin
				att_q  <= att_q + AW'(1);
				slot_q <= '0;
			end
			if (cmd.scan_init) begin
				idx_q <= '0;
				x_q   <= '0;
				y_q   <= '0;
				n_q   <= '0;
				k_q   <= '0;
			end else if (cmd.scan_step && !scan_end) begin
				if (take) begin
					cx_q[slot_q] <= x_q;
					cy_q[slot_q] <= y_q;
				end else if (all_checked || !sep) begin
					if (all_checked) begin
						n_q <= n_q + COUNT_BITS'(1);
					end
					idx_q <= idx_q + COUNT_BITS'(1);
					k_q   <= '0;
					if (WIDTH_BITS'(x_q) + WIDTH_BITS'(1) == eff_w_q) begin
						x_q <= '0;
						y_q <= y_q + SIDE_BITS'(1);
					end else begin
						x_q <= x_q + SIDE_BITS'(1);
					end
				end else begin
					k_q <= k_q + KW'(1);
				end
			end
			if (cmd.lim_store) begin
				limit_q <= rem;
			end
			if (cmd.rank_store) begin
				rank_q <= rem;
			end
			if (cmd.next_slot) begin
				slot_q <= slot_q + KW'(1);
			end
			if (cmd.set_ok) begin
				ok_q <= 1'b1;
			end
		end
	end

	assign dividend = cmd.lim_start ? (64'd0 - 64'(n_q)) : word;

	sogs_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (seed_load),
		.load_val (seed),
		.start    (cmd.gen_start),
		.done     (gen_done),
		.word     (word)
	);

	sogs_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.lim_start || cmd.rank_start),
		.dividend (dividend),
		.divisor  (n_q),
		.done     (mod_done),
		.rem      (rem)
	);

	always_comb begin
		sts.scan_end    = scan_end;
		sts.hit         = take;
		sts.n_zero      = (n_q == '0);
		sts.att_last    = (att_q == AW'(MAX_RESTARTS));
		sts.slot_last   = (slot_q == KW'(GROUP_SIZE - 1));
		sts.gen_done    = gen_done;
		sts.mod_done    = mod_done;
		sts.below_limit = (word < 64'(limit_q));
	end

	// Slots past the group size, and every slot of a failed group, read as zero.
	always_comb begin
		coord_t ox [OUT_SLOTS];
		coord_t oy [OUT_SLOTS];
		for (int i = 0; i < OUT_SLOTS; i++) begin
			ox[i] = '0;
			oy[i] = '0;
			if (ok_q && i < GROUP_SIZE) begin
				ox[i] = cx_q[i % GROUP_SIZE];
				oy[i] = cy_q[i % GROUP_SIZE];
			end
		end
		res.first_x  = ox[0];
		res.first_y  = oy[0];
		res.second_x = ox[1];
		res.second_y = oy[1];
		res.third_x  = ox[2];
		res.third_y  = oy[2];
		res.fourth_x = ox[3];
		res.fourth_y = oy[3];
		res.ok       = ok_q;
	end
endmodule
`default_nettype wire

// ===== hdl/separated_origin_group_sampler.sv =====
// Draws a group of separated grid origins for each request item.
// Channels: req carries one request bit per item; res returns one item per
// request with four origin coordinates and ok. An item with request low is
// taken and dropped without a result. Configuration is written through
// cfg_we/cfg_index/cfg_data while the block is idle; writing the seed also
// reloads the generator.
// Work per slot: a counting scan over the C candidate origins, each checked
// against the slots already chosen, one per cycle; the rejection limit; the
// generator words; the rank; and a picking scan that stops at the chosen
// origin. Each restart after a dead end repeats this work, and the scans
// take the largest share of the time.
// One request is worked at a time; a new one is taken once the previous
// result sits in the output register, even if the receiver has not taken it.
// When the receiver stalls, the finished result waits and no further item
// is taken. Reset restores the register defaults and a zero generator state.
`default_nettype none
module separated_origin_group_sampler #(
	parameter int GROUP_SIZE   = sogs_pkg::GROUP_SIZE,
	parameter int MAX_RESTARTS = sogs_pkg::MAX_RESTARTS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	sogs_req_if.sink                                 req,
	sogs_res_if.source                               res,
	input  wire logic                                cfg_we,
	input  wire logic [sogs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [sogs_pkg::SEED_BITS-1:0]      cfg_data
);
	import sogs_pkg::*;

	logic [WIDTH_BITS-1:0] width_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [DIST_BITS-1:0]  dist_q;
	logic                  seed_load, in_ready, out_free, out_valid_q;
	sogs_cmd_t             cmd;
	sogs_sts_t             sts;
	sogs_res_t             res_d, res_q;

	// The seed register lives in the generator state, loaded on a write.
	assign seed_load = cfg_we && (cfg_index == CFG_SEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RST_ORIGIN_WIDTH;
			count_q <= RST_ORIGIN_COUNT;
			dist_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ORIGIN_WIDTH: width_q <= cfg_data[WIDTH_BITS-1:0];
				CFG_ORIGIN_COUNT: count_q <= cfg_data[COUNT_BITS-1:0];
				CFG_MIN_DISTANCE: dist_q  <= cfg_data[DIST_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign out_free  = !out_valid_q || res.ready;
	assign req.ready = in_ready;

	sogs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_fire (req.valid && in_ready),
		.request  (req.request),
		.out_free (out_free),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	sogs_dp #(
		.GROUP_SIZE   (GROUP_SIZE),
		.MAX_RESTARTS (MAX_RESTARTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.origin_width (width_q),
		.origin_count (count_q),
		.min_distance (dist_q),
		.seed_load    (seed_load),
		.seed         (cfg_data),
		.sts          (sts),
		.res          (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q <= res_d;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.first_x  = res_q.first_x;
	assign res.first_y  = res_q.first_y;
	assign res.second_x = res_q.second_x;
	assign res.second_y = res_q.second_y;
	assign res.third_x  = res_q.third_x;
	assign res.third_y  = res_q.third_y;
	assign res.fourth_x = res_q.fourth_x;
	assign res.fourth_y = res_q.fourth_y;
	assign res.ok       = res_q.ok;
endmodule
`default_nettype wire

// ===== test/sogs_group_checker.sv =====
`default_nettype none
module sogs_group_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	sogs_req_if                                    req_mon,
	sogs_res_if                                    res_mon,
	input  wire logic                              cfg_we,
	input  wire logic [sogs_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [sogs_pkg::SEED_BITS-1:0]    cfg_data,
	output int                                     fails,
	output int                                     pending
);
	import sogs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the configuration and the generator.
	int unsigned     grid_width;
	int unsigned     grid_count;
	int unsigned     sep_dist;
	logic [63:0]     gen_state;
	int unsigned     eff_width;
	longint unsigned eff_count;
	int unsigned     pick_x [GROUP_SIZE];
	int unsigned     pick_y [GROUP_SIZE];
	sogs_res_t       expected_groups [$];

	function automatic logic [63:0] next_word();
		logic [63:0] z;
		gen_state = gen_state + GOLDEN;
		z = gen_state;
		z = (z ^ (z >> SHIFT_A)) * MIX_C1;
		z = (z ^ (z >> SHIFT_B)) * MIX_C2;
		return z ^ (z >> SHIFT_C);
	endfunction

	// Rejection sampling keeps the rank unbiased.
	function automatic logic [63:0] draw_below(logic [63:0] bound);
		logic [63:0] lim;
		logic [63:0] v;
		lim = (64'd0 - bound) % bound;
		do
			v = next_word();
		while (v < lim);
		return v % bound;
	endfunction

	function automatic bit separated_from(int unsigned ax, int unsigned ay,
			int unsigned bx, int unsigned by);
		longint unsigned dx;
		longint unsigned dy;
		longint unsigned d;
		if (ax == bx && ay == by)
			return 1'b0;
		if (sep_dist == 0)
			return 1'b1;
		dx = ax > bx ? ax - bx : bx - ax;
		dy = ay > by ? ay - by : by - ay;
		d = sep_dist;
		return dx * dx + dy * dy >= d * d;
	endfunction

	function automatic bit fits(int unsigned x, int unsigned y, int filled);
		for (int k = 0; k < filled; k++)
			if (!separated_from(x, y, pick_x[k], pick_y[k]))
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic longint unsigned scan_slot(int slot, bit pick, longint unsigned rank);
		longint unsigned n;
		int unsigned x;
		int unsigned y;
		n = 0;
		x = 0;
		y = 0;
		for (longint unsigned i = 0; i < eff_count; i++) begin
			if (fits(x, y, slot)) begin
				if (pick && n == rank) begin
					pick_x[slot] = x;
					pick_y[slot] = y;
					return n;
				end
				n++;
			end
			x++;
			if (x == eff_width) begin
				x = 0;
				y++;
			end
		end
		return n;
	endfunction

	function automatic sogs_res_t draw_group();
		sogs_res_t r;
		bit found;
		int slot;
		longint unsigned n;
		eff_width = grid_width == 0 ? 1 : grid_width;
		if (eff_width > MAX_SIDE)
			eff_width = MAX_SIDE;
		eff_count = grid_count;
		if (eff_count > longint'(eff_width) * MAX_SIDE)
			eff_count = longint'(eff_width) * MAX_SIDE;
		found = 1'b0;
		for (int a = 0; a < MAX_RESTARTS && !found; a++) begin
			for (slot = 0; slot < GROUP_SIZE; slot++) begin
				n = scan_slot(slot, 1'b0, 0);
				if (n == 0)
					break;
				void'(scan_slot(slot, 1'b1, draw_below(n)));
			end
			if (slot == GROUP_SIZE)
				found = 1'b1;
		end
		r = '0;
		if (found) begin
			r.first_x  = coord_t'(pick_x[0]);
			r.first_y  = coord_t'(pick_y[0]);
			r.second_x = coord_t'(pick_x[1]);
			r.second_y = coord_t'(pick_y[1]);
			r.third_x  = coord_t'(pick_x[2]);
			r.third_y  = coord_t'(pick_y[2]);
			r.fourth_x = coord_t'(pick_x[3]);
			r.fourth_y = coord_t'(pick_y[3]);
		end
		r.ok = found;
		return r;
	endfunction

	task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sogs_res_t e;
		if (!arst_n) begin
			grid_width = RST_ORIGIN_WIDTH;
			grid_count = RST_ORIGIN_COUNT;
			sep_dist = 0;
			gen_state = '0;
			expected_groups.delete();
			fails = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ORIGIN_WIDTH: grid_width = cfg_data[WIDTH_BITS-1:0];
					CFG_ORIGIN_COUNT: grid_count = cfg_data[COUNT_BITS-1:0];
					CFG_MIN_DISTANCE: sep_dist = cfg_data[DIST_BITS-1:0];
					CFG_SEED:         gen_state = cfg_data;
				endcase
			end
			if (res_mon.valid && res_mon.ready) begin
				if (expected_groups.size() == 0) begin
					$error("result item with no request outstanding");
					fails++;
				end else begin
					e = expected_groups.pop_front();
					check_field("first_x", e.first_x, res_mon.first_x);
					check_field("first_y", e.first_y, res_mon.first_y);
					check_field("second_x", e.second_x, res_mon.second_x);
					check_field("second_y", e.second_y, res_mon.second_y);
					check_field("third_x", e.third_x, res_mon.third_x);
					check_field("third_y", e.third_y, res_mon.third_y);
					check_field("fourth_x", e.fourth_x, res_mon.fourth_x);
					check_field("fourth_y", e.fourth_y, res_mon.fourth_y);
					check_field("ok", e.ok, res_mon.ok);
				end
			end
			if (req_mon.valid && req_mon.ready && req_mon.request)
				expected_groups.push_back(draw_group());
			pending <= expected_groups.size();
		end
	end
endmodule
`default_nettype wire

// ===== test/separated_origin_group_sampler_tb.sv =====
`default_nettype none
module separated_origin_group_sampler_tb;
	import sogs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [SEED_BITS-1:0]    cfg_data;
	int                      fails;
	int                      pending;
	int                      send_idle;
	int                      recv_idle;
	int                      hold_cycles;

	sogs_req_if req_ch ();
	sogs_res_if res_ch ();

	separated_origin_group_sampler dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .res(res_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	sogs_group_checker checker_i (
		.clk(clk), .arst_n(arst_n), .req_mon(req_ch), .res_mon(res_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2s;
		$display("Some tests failed");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= $urandom_range(99) >= recv_idle;
		end
	end

	task automatic send_item(bit r);
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.request <= r;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// Waits until every expected result is in and the block has settled.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SEED_BITS-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_grid(int unsigned w, int unsigned c, int unsigned d);
		drain();
		write_reg(CFG_ORIGIN_WIDTH, 64'(w));
		write_reg(CFG_ORIGIN_COUNT, 64'(c));
		write_reg(CFG_MIN_DISTANCE, 64'(d));
	endtask

	task automatic random_phase(int groups);
		int unsigned w;
		int unsigned c;
		int unsigned d;
		w = $urandom_range(1, 40);
		c = $urandom_range(0, 9) == 0 ? $urandom_range(0, 6) : $urandom_range(4, 600);
		d = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1449) : $urandom_range(0, 12);
		set_grid(w, c, d);
		if ($urandom_range(1) == 1)
			write_reg(CFG_SEED, {$urandom, $urandom});
		for (int i = 0; i < groups; i++)
			send_item($urandom_range(9) != 0);
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.request = 1'b0;
		res_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ORIGIN_WIDTH;
		cfg_data = '0;
		send_idle = 0;
		recv_idle = 0;
		hold_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: small grids, clamped widths and counts, dead ends.
		set_grid(4, 16, 0);
		send_item(1'b1);
		send_item(1'b0);
		send_item(1'b1);
		set_grid(0, 8, 0);
		send_item(1'b1);
		set_grid(2047, 3000, 0);
		write_reg(CFG_SEED, '1);
		send_item(1'b1);
		set_grid(1, 2097151, 300);
		send_item(1'b1);
		send_item(1'b1);
		set_grid(4, 4, 2);
		send_item(1'b1);
		set_grid(8, 64, 1449);
		send_item(1'b1);
		set_grid(4, 0, 0);
		send_item(1'b1);
		set_grid(4, 1, 0);
		send_item(1'b1);
		set_grid(1024, 2048, 1);
		write_reg(CFG_SEED, 64'd0);
		send_item(1'b1);
		send_item(1'b1);
		set_grid(32, 2097151, 40);
		send_item(1'b1);
		set_grid(16, 256, 5);
		send_item(1'b1);
		send_item(1'b0);
		send_item(1'b1);

		// Long receiver hold-off while items keep coming, so the input stalls.
		hold_cycles <= 40000;
		@(posedge clk);
		for (int i = 0; i < 4; i++)
			send_item(1'b1);
		drain();

		send_idle = 31;
		recv_idle = 88;
		for (int p = 0; p < 4; p++)
			random_phase(6);
		send_idle = 88;
		recv_idle = 31;
		for (int p = 0; p < 4; p++)
			random_phase(6);
		send_idle = 0;
		recv_idle = 0;
		for (int p = 0; p < 4; p++) begin
			random_phase(6);
			// Sender pauses until the block has handed everything back.
			req_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while (pending != 0);
			for (int i = 0; i < 3; i++)
				send_item($urandom_range(1));
		end

		drain();
		repeat (200) @(posedge clk);
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/sogs_pkg.sv
hdl/sogs_if.sv
hdl/sogs_mix.sv
hdl/sogs_mod.sv
hdl/sogs_ctrl.sv
hdl/sogs_dp.sv
hdl/separated_origin_group_sampler.sv
test/sogs_group_checker.sv
test/separated_origin_group_sampler_tb.sv
